// ===== sv/aarch64_branch_target_marker_macros.svh =====
// Assertion macros for the branch target marker RTL.
// Included by the modules that carry assertions; needs clk_i and rst_ni in scope.
`ifndef AARCH64_BRANCH_TARGET_MARKER_MACROS_SVH
`define AARCH64_BRANCH_TARGET_MARKER_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ABTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ABTM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ABTM_ASSERT(lbl, prop, msg)
`define ABTM_NEVER(lbl, cond, msg)

`endif

`endif

// ===== sv/abtm_pkg.sv =====
// Shared types and constants of the branch target marker.
// No dependencies; used by every module of the block.
`default_nettype none

package abtm_pkg;

  localparam int MAX_WORDS = 16384;
  localparam int MAP_AW    = $clog2(MAX_WORDS);
  localparam int IDX_W     = 14;
  localparam int SECT_W    = 15;
  localparam int OFF_W     = 26;
  localparam int TGT_W     = OFF_W + 1;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int CMD_DEPTH = 2;

  localparam logic [SECT_W-1:0] MAX_LIMIT = SECT_W'(MAX_WORDS);

  // Opcode matching
  localparam logic [5:0]  OP_B      = 6'h05;
  localparam logic [5:0]  OP_BL     = 6'h25;
  localparam logic [31:0] BCOND_MSK = 32'hFF000000;
  localparam logic [31:0] BCOND_VAL = 32'h54000000;
  localparam logic [31:0] CBTB_MSK  = 32'h7E000000;
  localparam logic [31:0] CB_VAL    = 32'h34000000;
  localparam logic [31:0] TB_VAL    = 32'h36000000;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_B     = 3'd1,
    KIND_BCOND = 3'd2,
    KIND_CB    = 3'd3,
    KIND_TB    = 3'd4
  } branch_kind_e;

  typedef enum logic {
    REQ_SCAN  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  // Decoded command handed from front to back
  typedef struct packed {
    logic                    is_query;
    logic                    query_ok;
    branch_kind_e            kind;
    logic signed [OFF_W-1:0] offset;
    logic                    in_range;
    logic [MAP_AW-1:0]       addr;
  } cmd_t;

  typedef struct packed {
    branch_kind_e            kind;
    logic signed [OFF_W-1:0] offset;
    logic                    in_range;
    logic                    marked;
  } result_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

// ===== sv/abtm_front.sv =====
// Front end: section length register, instruction decode and target range check.
// Depends on abtm_pkg.
`default_nettype none

module abtm_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [abtm_pkg::SECT_W-1:0]         cfg_wdata_i,
  input  wire logic                                req_type_i,
  input  wire logic [abtm_pkg::IDX_W-1:0]          word_index_i,
  input  wire logic [31:0]                         instr_word_i,
  output abtm_pkg::cmd_t                           cmd_o
);

  logic [abtm_pkg::SECT_W-1:0]               section_q, section_d;
  logic [abtm_pkg::SECT_W-1:0]               limit;
  abtm_pkg::branch_kind_e                    kind;
  logic signed [abtm_pkg::OFF_W-1:0]         offset;
  logic [abtm_pkg::TGT_W-1:0]                target;
  logic                                      is_query;

  always_comb begin
    section_d = section_q;
    if (cfg_we_i) begin
      section_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q <= '0;
    end else begin
      section_q <= section_d;
    end
  end

  assign limit    = (section_q > abtm_pkg::MAX_LIMIT) ? abtm_pkg::MAX_LIMIT : section_q;
  assign is_query = (req_type_i == abtm_pkg::REQ_QUERY);

  // First match wins, in the order below
  always_comb begin
    kind   = abtm_pkg::KIND_NONE;
    offset = '0;
    if (!is_query) begin
      if (instr_word_i[31:26] == abtm_pkg::OP_B || instr_word_i[31:26] == abtm_pkg::OP_BL) begin
        kind   = abtm_pkg::KIND_B;
        offset = instr_word_i[25:0];
      end else if ((instr_word_i & abtm_pkg::BCOND_MSK) == abtm_pkg::BCOND_VAL) begin
        kind   = abtm_pkg::KIND_BCOND;
        offset = {{7{instr_word_i[23]}}, instr_word_i[23:5]};
      end else if ((instr_word_i & abtm_pkg::CBTB_MSK) == abtm_pkg::CB_VAL) begin
        kind   = abtm_pkg::KIND_CB;
        offset = {{7{instr_word_i[23]}}, instr_word_i[23:5]};
      end else if ((instr_word_i & abtm_pkg::CBTB_MSK) == abtm_pkg::TB_VAL) begin
        kind   = abtm_pkg::KIND_TB;
        offset = {{12{instr_word_i[18]}}, instr_word_i[18:5]};
      end
    end
  end

  // Target word index, one bit wider than the offset to keep the sign
  assign target = {{(abtm_pkg::TGT_W-abtm_pkg::IDX_W){1'b0}}, word_index_i}
                + {offset[abtm_pkg::OFF_W-1], offset};

  always_comb begin
    cmd_o          = '0;
    cmd_o.is_query = is_query;
    cmd_o.query_ok = ({1'b0, word_index_i} < abtm_pkg::MAX_LIMIT);
    cmd_o.kind     = kind;
    cmd_o.offset   = offset;
    cmd_o.in_range = (kind != abtm_pkg::KIND_NONE) && !target[abtm_pkg::TGT_W-1]
                   && (target[abtm_pkg::OFF_W-1:0]
                       < {{(abtm_pkg::OFF_W-abtm_pkg::SECT_W){1'b0}}, limit});
    cmd_o.addr     = is_query ? word_index_i[abtm_pkg::MAP_AW-1:0]
                              : target[abtm_pkg::MAP_AW-1:0];
  end

endmodule

`default_nettype wire

// ===== sv/abtm_cmd_queue.sv =====
// Two-entry command queue between decode front and bitmap back end.
// Depends on abtm_pkg.
`default_nettype none

module abtm_cmd_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  abtm_pkg::cmd_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output abtm_pkg::cmd_t data_o
);

  abtm_pkg::cmd_t slot_q [abtm_pkg::CMD_DEPTH];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(abtm_pkg::CMD_DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/abtm_back.sv =====
// Back end: target bitmap memory with clearing sweep, and the result queue.
// Depends on abtm_pkg and the assertion macros header.
`default_nettype none
`include "aarch64_branch_target_marker_macros.svh"

module abtm_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  abtm_pkg::cmd_t          cmd_i,
  output logic                    cmd_pop_o,
  output abtm_pkg::back_status_t  status_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output abtm_pkg::result_t       result_o
);

  localparam int CNT_W = abtm_pkg::OUT_AW + 1;

  // Bitmap, one bit per word; cleared by a sweep after reset
  logic                          map_mem [abtm_pkg::MAX_WORDS];
  logic                          rd_q;
  logic                          mem_we;
  logic                          mem_wbit;
  logic [abtm_pkg::MAP_AW-1:0]   mem_waddr;
  logic                          mem_re;

  logic                          clearing_q, clearing_d;
  logic [abtm_pkg::MAP_AW-1:0]   clr_addr_q, clr_addr_d;

  // Command in flight, waiting for read data
  logic                          infl_q, infl_d;
  abtm_pkg::result_t             infl_res_q;
  logic                          infl_rd_q;

  // Result queue
  abtm_pkg::result_t             out_q [abtm_pkg::OUT_DEPTH];
  logic [abtm_pkg::OUT_AW-1:0]   out_wptr_q, out_wptr_d;
  logic [abtm_pkg::OUT_AW-1:0]   out_rptr_q, out_rptr_d;
  logic [CNT_W-1:0]              out_cnt_q, out_cnt_d;
  logic                          out_push;
  logic                          out_pop;
  abtm_pkg::result_t             push_res;
  logic [CNT_W:0]                used;

  assign status_o.clearing = clearing_q;

  // Reserve a result slot for every command in flight
  assign used      = {1'b0, out_cnt_q} + {{CNT_W{1'b0}}, infl_q};
  assign cmd_pop_o = !clearing_q && cmd_valid_i && (used < (CNT_W+1)'(abtm_pkg::OUT_DEPTH));

  assign mem_re    = cmd_pop_o && cmd_i.is_query;
  assign mem_we    = clearing_q || (cmd_pop_o && !cmd_i.is_query && cmd_i.in_range);
  assign mem_wbit  = !clearing_q;
  assign mem_waddr = clearing_q ? clr_addr_q : cmd_i.addr;

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wbit;
    end
    if (mem_re) begin
      rd_q <= map_mem[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      infl_res_q.kind     <= cmd_i.kind;
      infl_res_q.offset   <= cmd_i.offset;
      infl_res_q.in_range <= cmd_i.in_range;
      infl_res_q.marked   <= 1'b0;
      infl_rd_q           <= cmd_i.is_query && cmd_i.query_ok;
    end
  end

  assign infl_d   = cmd_pop_o;
  assign out_push = infl_q;
  assign out_pop  = pop_i && !empty_o;

  always_comb begin
    push_res        = infl_res_q;
    push_res.marked = infl_rd_q && rd_q;
  end

  always_comb begin
    out_wptr_d = out_wptr_q;
    out_rptr_d = out_rptr_q;
    out_cnt_d  = out_cnt_q;
    if (out_push) begin
      out_wptr_d = out_wptr_q + 1'b1;
    end
    if (out_pop) begin
      out_rptr_d = out_rptr_q + 1'b1;
    end
    case ({out_push, out_pop})
      2'b10:   out_cnt_d = out_cnt_q + 1'b1;
      2'b01:   out_cnt_d = out_cnt_q - 1'b1;
      default: out_cnt_d = out_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q[out_wptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      infl_q     <= 1'b0;
      out_wptr_q <= '0;
      out_rptr_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      infl_q     <= infl_d;
      out_wptr_q <= out_wptr_d;
      out_rptr_q <= out_rptr_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  assign empty_o  = (out_cnt_q == '0);
  assign result_o = out_q[out_rptr_q];

  `ABTM_ASSERT(a_slot_reserved, used <= (CNT_W+1)'(abtm_pkg::OUT_DEPTH), "result queue overbooked")
  `ABTM_NEVER(a_no_cmd_in_sweep, clearing_q && cmd_pop_o, "command taken during clearing sweep")
  `ABTM_ASSERT(a_pop_lands, cmd_pop_o |=> out_push, "popped command produced no result")
  `ABTM_NEVER(a_sweep_no_result, clearing_q && !empty_o, "result present during clearing sweep")

endmodule

`default_nettype wire

// ===== sv/aarch64_branch_target_marker.sv =====
// AArch64 branch target marker: an item taken is decoded in the front, queued, then
// looked up or marked in the bitmap in the back and put in the result queue.
// Throughput one item per cycle unless the sweep or a full result queue stalls it,
// set by the bitmap taking one access a beat. After reset the bitmap is swept clear
// with full held high; section_q resets to 0 and config writes are taken during the sweep.
// Depends on abtm_pkg, abtm_front, abtm_cmd_queue and abtm_back.
`default_nettype none

module aarch64_branch_target_marker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [abtm_pkg::SECT_W-1:0]   cfg_wdata_i,
  // input queue side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          req_type_i,
  input  wire logic [abtm_pkg::IDX_W-1:0]    word_index_i,
  input  wire logic [31:0]                   instr_word_i,
  // result queue side
  output logic                               empty,
  input  wire logic                          pop,
  output logic [2:0]                         branch_kind_o,
  output logic signed [abtm_pkg::OFF_W-1:0]  branch_offset_o,
  output logic                               target_in_range_o,
  output logic                               is_marked_o
);

  abtm_pkg::cmd_t          front_cmd;
  abtm_pkg::cmd_t          q_cmd;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;
  logic                    q_push;
  abtm_pkg::back_status_t  back_status;
  abtm_pkg::result_t       result;

  // Hold off new beats while the queue is full or the bitmap is still being cleared
  assign full   = q_full || back_status.clearing;
  assign q_push = push && !full;

  // Decode and range check, combinational up to the queue
  abtm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .word_index_i (word_index_i),
    .instr_word_i (instr_word_i),
    .cmd_o        (front_cmd)
  );

  // Decouple decode from bitmap access so each side may stall on its own
  abtm_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  // Mark or read the bitmap in order, so a query sees every earlier mark
  abtm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .status_o    (back_status),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result)
  );

  assign branch_kind_o     = result.kind;
  assign branch_offset_o   = result.offset;
  assign target_in_range_o = result.in_range;
  assign is_marked_o       = result.marked;

endmodule

`default_nettype wire
